// ===== src/stream_find_replace_assert.svh =====
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH

// same-cycle implication
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int MAX_SUBST_DEF   = 16;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 5;
    localparam int WORD_W          = 64;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LEN = 3'd0,
        REG_PATTERN_LO  = 3'd1,
        REG_PATTERN_HI  = 3'd2,
        REG_SUBST_LEN   = 3'd3,
        REG_SUBST_LO    = 3'd4,
        REG_SUBST_HI    = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUBST,
        S_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        WIN_HOLD,
        WIN_PUSH,
        WIN_PUSH_SHIFT,
        WIN_SHIFT,
        WIN_CLEAR
    } t_win_op;

    typedef enum logic [1:0] {
        OUT_IN,
        OUT_EMPTY,
        OUT_WIN,
        OUT_SUB
    } t_out_sel;

    typedef struct packed {
        t_win_op  win_op;
        logic     emit;
        t_out_sel out_sel;
        logic     out_last;
        logic     sub_load;
        logic     sub_shift;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic plen_zero;
        logic full;
        logic match;
        logic count_zero;
        logic count_one;
        logic slen_zero;
        logic sub_one;
    } t_dp_stat;

endpackage

// ===== src/sfr_if.sv =====
`timescale 1ns / 1ps

interface sfr_in_if;
    logic                        valid;
    logic                        ready;
    logic [sfr_pkg::BYTE_W-1:0]  in_byte;
    logic                        in_has_byte;
    logic                        in_last;

    modport source (output valid, output in_byte, output in_has_byte, output in_last,
                    input ready);
    modport sink   (input valid, input in_byte, input in_has_byte, input in_last,
                    output ready);
endinterface

interface sfr_out_if;
    logic                        valid;
    logic                        ready;
    logic [sfr_pkg::BYTE_W-1:0]  out_byte;
    logic                        out_has_byte;
    logic                        out_last;

    modport source (output valid, output out_byte, output out_has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_has_byte, input out_last,
                    output ready);
endinterface

interface sfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sfr_pkg::WORD_W-1:0]    cfg_data;

    modport source (output valid, output cfg_index, output cfg_data, input ready);
    modport sink   (input valid, input cfg_index, input cfg_data, output ready);
endinterface

// ===== src/stream_find_replace.sv =====
`timescale 1ns / 1ps

// channel  | dir | beat contents                        | handshake
// ---------+-----+--------------------------------------+-------------
// i_in     | in  | in_byte, in_has_byte, in_last        | valid/ready
// o_out    | out | out_byte, out_has_byte, out_last     | valid/ready
// i_cfg    | in  | cfg_index, cfg_data                  | valid/ready
//
// an input beat that yields at most one output beat does not stall the input; the
// output register delivers one beat per cycle while o_out.ready stays high
// a match sends its subst_len replacement beats, an end marker flushes the held bytes
// i_in.ready drops while replacement or flush beats go out, or the output stalls
// reset (synchronous, active low) clears the window count, the config and the fsm
// i_cfg.ready is always high; no clearing pass after reset

module stream_find_replace #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_SUBST   = sfr_pkg::MAX_SUBST_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfr_in_if.sink    i_in,
    sfr_out_if.source o_out,
    sfr_cfg_if.sink   i_cfg
);

    `include "stream_find_replace_assert.svh"

    sfr_pkg::t_dp_cmd  w_cmd;
    sfr_pkg::t_dp_stat w_stat;
    logic              w_in_ready;

    assign i_in.ready = w_in_ready;

    // controller: decides per beat whether to buffer, emit, replace or flush
    sfr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_has_byte (i_in.in_has_byte),
        .i_in_last     (i_in.in_last),
        .o_in_ready    (w_in_ready),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    // datapath: config registers, window shift line, match compare,
    // replacement shift line and the output register
    sfr_dp #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_SUBST   (MAX_SUBST)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_byte (i_in.in_byte),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_out     (o_out),
        .i_cfg     (i_cfg)
    );

    // a beat is only loaded into a free output slot
    `SFR_ASSERT_NOW(a_emit_into_free, w_cmd.emit, w_stat.slot_free, "beat over held beat")
    // replacement beats never overlap an accepted input beat
    `SFR_ASSERT_NOW(a_sub_no_take, i_in.valid && w_in_ready, !w_cmd.sub_shift, "took input")
    // a loaded beat is offered on the next cycle
    `SFR_ASSERT_NEXT(a_emit_shows, w_cmd.emit, o_out.valid, "loaded beat not offered")

endmodule

// ===== src/sfr_dp.sv =====
`timescale 1ns / 1ps

module sfr_dp #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_SUBST   = sfr_pkg::MAX_SUBST_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [sfr_pkg::BYTE_W-1:0] i_in_byte,
    input  sfr_pkg::t_dp_cmd           i_cmd,
    output sfr_pkg::t_dp_stat          o_stat,
    sfr_out_if.source                  o_out,
    sfr_cfg_if.sink                    i_cfg
);

    localparam int BW = sfr_pkg::BYTE_W;
    localparam int LW = sfr_pkg::LEN_W;
    localparam int WW = sfr_pkg::WORD_W;
    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int SW = $clog2(MAX_SUBST + 1);

    // configuration
    logic [LW-1:0] r_pattern_len;
    logic [WW-1:0] r_pattern_lo;
    logic [WW-1:0] r_pattern_hi;
    logic [LW-1:0] r_subst_len;
    logic [WW-1:0] r_subst_lo;
    logic [WW-1:0] r_subst_hi;

    // window and replacement shift lines
    logic [BW-1:0] r_win [MAX_PATTERN];
    logic [CW-1:0] r_count;
    logic [BW-1:0] r_sub [MAX_SUBST];
    logic [SW-1:0] r_sub_left;

    // output register
    logic          r_out_valid;
    logic [BW-1:0] r_out_byte;
    logic          r_out_has;
    logic          r_out_last;

    logic            w_cfg_wr;
    logic [CW-1:0]   w_plen;
    logic [SW-1:0]   w_slen;
    logic [2*WW-1:0] w_pat_word;
    logic [2*WW-1:0] w_sub_word;
    logic [BW-1:0]   w_merged [MAX_PATTERN];
    logic            w_match;
    logic [BW-1:0]   w_out_byte;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_len <= '0;
            r_pattern_lo  <= '0;
            r_pattern_hi  <= '0;
            r_subst_len   <= '0;
            r_subst_lo    <= '0;
            r_subst_hi    <= '0;
        end else if (w_cfg_wr) begin
            case (sfr_pkg::t_reg_idx'(i_cfg.cfg_index))
                sfr_pkg::REG_PATTERN_LEN: r_pattern_len <= i_cfg.cfg_data[LW-1:0];
                sfr_pkg::REG_PATTERN_LO:  r_pattern_lo  <= i_cfg.cfg_data;
                sfr_pkg::REG_PATTERN_HI:  r_pattern_hi  <= i_cfg.cfg_data;
                sfr_pkg::REG_SUBST_LEN:   r_subst_len   <= i_cfg.cfg_data[LW-1:0];
                sfr_pkg::REG_SUBST_LO:    r_subst_lo    <= i_cfg.cfg_data;
                sfr_pkg::REG_SUBST_HI:    r_subst_hi    <= i_cfg.cfg_data;
                default: ;
            endcase
        end
    end

    // lengths above the build limits saturate
    assign w_plen = (r_pattern_len > LW'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : CW'(r_pattern_len);
    assign w_slen = (r_subst_len > LW'(MAX_SUBST)) ? SW'(MAX_SUBST) : SW'(r_subst_len);

    assign w_pat_word = {r_pattern_hi, r_pattern_lo};
    assign w_sub_word = {r_subst_hi, r_subst_lo};

    // window as it would be with the incoming byte written at the fill point
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_merged[i] = (r_count == CW'(i)) ? i_in_byte : r_win[i];
        end
    end

    always_comb begin
        w_match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((CW'(i) < w_plen) && (w_merged[i] != w_pat_word[BW*i +: BW])) begin
                w_match = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_cfg_wr &&
                     (sfr_pkg::t_reg_idx'(i_cfg.cfg_index) == sfr_pkg::REG_PATTERN_LEN)) begin
            r_count <= '0;
        end else begin
            case (i_cmd.win_op)
                sfr_pkg::WIN_PUSH:  r_count <= r_count + CW'(1);
                sfr_pkg::WIN_SHIFT: r_count <= r_count - CW'(1);
                sfr_pkg::WIN_CLEAR: r_count <= '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.win_op)
            sfr_pkg::WIN_PUSH: begin
                for (int i = 0; i < MAX_PATTERN; i++) begin
                    if (r_count == CW'(i)) r_win[i] <= i_in_byte;
                end
            end
            sfr_pkg::WIN_PUSH_SHIFT: begin
                for (int i = 0; i < MAX_PATTERN - 1; i++) r_win[i] <= w_merged[i+1];
            end
            sfr_pkg::WIN_SHIFT: begin
                for (int i = 0; i < MAX_PATTERN - 1; i++) r_win[i] <= r_win[i+1];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sub_load) begin
            for (int i = 0; i < MAX_SUBST; i++) r_sub[i] <= w_sub_word[BW*i +: BW];
        end else if (i_cmd.sub_shift) begin
            for (int i = 0; i < MAX_SUBST - 1; i++) r_sub[i] <= r_sub[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_left <= '0;
        end else if (i_cmd.sub_load) begin
            r_sub_left <= w_slen;
        end else if (i_cmd.sub_shift) begin
            r_sub_left <= r_sub_left - SW'(1);
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            sfr_pkg::OUT_IN:  w_out_byte = i_in_byte;
            sfr_pkg::OUT_WIN: w_out_byte = w_merged[0];
            sfr_pkg::OUT_SUB: w_out_byte = r_sub[0];
            default:          w_out_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= w_out_byte;
            r_out_has  <= (i_cmd.out_sel != sfr_pkg::OUT_EMPTY);
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.out_has_byte = r_out_has;
    assign o_out.out_last     = r_out_last;

    always_comb begin
        o_stat.slot_free  = !r_out_valid || o_out.ready;
        o_stat.plen_zero  = (w_plen == '0);
        o_stat.full       = ((r_count + CW'(1)) == w_plen);
        o_stat.match      = w_match;
        o_stat.count_zero = (r_count == '0);
        o_stat.count_one  = (r_count == CW'(1));
        o_stat.slen_zero  = (w_slen == '0);
        o_stat.sub_one    = (r_sub_left == SW'(1));
    end

endmodule

// ===== src/sfr_ctrl.sv =====
`timescale 1ns / 1ps

module sfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_has_byte,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  sfr_pkg::t_dp_stat i_stat,
    output sfr_pkg::t_dp_cmd  o_cmd
);

    sfr_pkg::t_state r_state;
    sfr_pkg::t_state n_state;
    logic            r_last;
    logic            n_last;
    logic            w_accept;

    assign o_in_ready = (r_state == sfr_pkg::S_IDLE) && i_stat.slot_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfr_pkg::S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfr_pkg::S_IDLE: begin
                if (w_accept && !i_stat.plen_zero) begin
                    if (i_in_has_byte && i_stat.full && i_stat.match) begin
                        if (!i_stat.slen_zero) n_state = sfr_pkg::S_SUBST;
                    end else if (i_in_has_byte && i_stat.full) begin
                        if (i_in_last && !i_stat.count_zero) n_state = sfr_pkg::S_FLUSH;
                    end else if (i_in_has_byte) begin
                        if (i_in_last) n_state = sfr_pkg::S_FLUSH;
                    end else if (i_in_last && !i_stat.count_zero) begin
                        n_state = sfr_pkg::S_FLUSH;
                    end
                end
            end
            sfr_pkg::S_SUBST: begin
                if (i_stat.slot_free && i_stat.sub_one) n_state = sfr_pkg::S_IDLE;
            end
            sfr_pkg::S_FLUSH: begin
                if (i_stat.slot_free && i_stat.count_one) n_state = sfr_pkg::S_IDLE;
            end
            default: n_state = sfr_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd.win_op    = sfr_pkg::WIN_HOLD;
        o_cmd.emit      = 1'b0;
        o_cmd.out_sel   = sfr_pkg::OUT_IN;
        o_cmd.out_last  = 1'b0;
        o_cmd.sub_load  = 1'b0;
        o_cmd.sub_shift = 1'b0;
        n_last          = r_last;
        case (r_state)
            sfr_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_stat.plen_zero) begin
                        o_cmd.win_op   = sfr_pkg::WIN_CLEAR;
                        o_cmd.emit     = i_in_has_byte || i_in_last;
                        o_cmd.out_sel  = i_in_has_byte ? sfr_pkg::OUT_IN : sfr_pkg::OUT_EMPTY;
                        o_cmd.out_last = i_in_last;
                    end else if (i_in_has_byte && i_stat.full && i_stat.match) begin
                        o_cmd.win_op   = sfr_pkg::WIN_CLEAR;
                        o_cmd.sub_load = 1'b1;
                        n_last         = i_in_last;
                        // deleting match at the end of the string leaves only the marker
                        o_cmd.emit     = i_stat.slen_zero && i_in_last;
                        o_cmd.out_sel  = sfr_pkg::OUT_EMPTY;
                        o_cmd.out_last = 1'b1;
                    end else if (i_in_has_byte && i_stat.full) begin
                        o_cmd.win_op   = sfr_pkg::WIN_PUSH_SHIFT;
                        o_cmd.emit     = 1'b1;
                        o_cmd.out_sel  = sfr_pkg::OUT_WIN;
                        o_cmd.out_last = i_in_last && i_stat.count_zero;
                    end else if (i_in_has_byte) begin
                        o_cmd.win_op = sfr_pkg::WIN_PUSH;
                    end else if (i_in_last && i_stat.count_zero) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.out_sel  = sfr_pkg::OUT_EMPTY;
                        o_cmd.out_last = 1'b1;
                    end
                end
            end
            sfr_pkg::S_SUBST: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.out_sel   = sfr_pkg::OUT_SUB;
                    o_cmd.out_last  = r_last && i_stat.sub_one;
                    o_cmd.sub_shift = 1'b1;
                end
            end
            sfr_pkg::S_FLUSH: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.out_sel  = sfr_pkg::OUT_WIN;
                    o_cmd.out_last = i_stat.count_one;
                    o_cmd.win_op   = sfr_pkg::WIN_SHIFT;
                end
            end
            default: ;
        endcase
    end

endmodule
